// ===== rtl/core/axis_rotation_matrix_generator_macros.svh =====
// ============================================================================
// Assertion macros for the axis rotation matrix generator
// Shared implication checks, clocked on the rising edge and held off in reset.
// ============================================================================
`ifndef AXIS_ROTATION_MATRIX_GENERATOR_MACROS_SVH
`define AXIS_ROTATION_MATRIX_GENERATOR_MACROS_SVH

// Same-cycle implication: the consequent holds whenever the antecedent does.
`define ARMG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// Next-cycle implication: the consequent holds in the cycle after the antecedent.
`define ARMG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`endif

// ===== rtl/core/armg_pkg.sv =====
// ============================================================================
// Axis rotation matrix generator package
// Fixed widths, codes and CORDIC constants shared by the pipeline modules.
// ============================================================================
package armg_pkg;

  // Field widths of the words on the ports.
  localparam int ANG_W = 24;
  localparam int SEL_W = 2;
  localparam int OUT_W = 18;

  // Axis selector codes.
  localparam logic [SEL_W-1:0] SEL_X     = 2'd0;
  localparam logic [SEL_W-1:0] SEL_Y     = 2'd1;
  localparam logic [SEL_W-1:0] SEL_Z     = 2'd2;
  localparam logic [SEL_W-1:0] SEL_IDENT = 2'd3;

  // Quadrant codes of the reduced angle.
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // Angle reduction: one quadrant is 90 degrees at 8 fraction bits.
  // Adding 92 full turns makes any input positive without changing it mod 360.
  localparam int V_W         = 25;
  localparam int QQ_W        = 10;
  localparam int R_W         = 15;
  localparam int T_SHIFT     = 9;
  localparam int T_W         = V_W - T_SHIFT;
  localparam int QUAD_UNITS  = 23040;
  localparam int ANGLE_BIAS  = 90112;
  // ceil(2^21 / 45): exact floor(t / 45) for every t below 2^16.
  localparam int RECIP_45    = 46604;
  localparam int RECIP_SHIFT = 21;
  localparam int RQ_W        = T_W + 17;

  // CORDIC working precision.
  localparam int WORK_BITS  = 38;
  localparam int XY_W       = WORK_BITS + 3;
  localparam int MAX_STAGES = 24;
  localparam real TWO_POW_WORK = 274877906944.0;

  // Degrees-to-radians step for one input unit, Q45.
  localparam int UNIT_RAD_FRAC = 45;
  localparam int ZP_W          = R_W + 32;
  localparam int Z_SH          = UNIT_RAD_FRAC - WORK_BITS;
  localparam logic [31:0] UNIT_RAD_Q45 =
    32'(longint'(3.14159265358979324 / 46080.0 * 35184372088832.0));

  // Inverse CORDIC gain, Q38.
  localparam longint GAIN_Q38 = longint'(0.60725293500888126 * TWO_POW_WORK);

  // Short arctangent series for small arguments 2^-i.
  function automatic real atan_small(int i);
    real x;
    x = 2.0 ** (-i);
    return x - (x ** 3) / 3.0 + (x ** 5) / 5.0 - (x ** 7) / 7.0;
  endfunction

  // Arctangent of 2^-i in Q38.
  localparam longint ATAN_Q38 [MAX_STAGES] = '{
    longint'(0.78539816339744831 * TWO_POW_WORK),
    longint'(0.46364760900080612 * TWO_POW_WORK),
    longint'(0.24497866312686416 * TWO_POW_WORK),
    longint'(0.12435499454676144 * TWO_POW_WORK),
    longint'(atan_small(4) * TWO_POW_WORK),
    longint'(atan_small(5) * TWO_POW_WORK),
    longint'(atan_small(6) * TWO_POW_WORK),
    longint'(atan_small(7) * TWO_POW_WORK),
    longint'(atan_small(8) * TWO_POW_WORK),
    longint'(atan_small(9) * TWO_POW_WORK),
    longint'(atan_small(10) * TWO_POW_WORK),
    longint'(atan_small(11) * TWO_POW_WORK),
    longint'(atan_small(12) * TWO_POW_WORK),
    longint'(atan_small(13) * TWO_POW_WORK),
    longint'(atan_small(14) * TWO_POW_WORK),
    longint'(atan_small(15) * TWO_POW_WORK),
    longint'(atan_small(16) * TWO_POW_WORK),
    longint'(atan_small(17) * TWO_POW_WORK),
    longint'(atan_small(18) * TWO_POW_WORK),
    longint'(atan_small(19) * TWO_POW_WORK),
    longint'(atan_small(20) * TWO_POW_WORK),
    longint'(atan_small(21) * TWO_POW_WORK),
    longint'(atan_small(22) * TWO_POW_WORK),
    longint'(atan_small(23) * TWO_POW_WORK)
  };

  // Side data that travels with each word down the pipeline.
  typedef struct packed {
    logic             zero;
    logic [1:0]       quad;
    logic [SEL_W-1:0] sel;
  } tag_t;

endpackage

// ===== rtl/core/axis_rotation_matrix_generator.sv =====
// ============================================================================
// Axis rotation matrix generator
// Builds the 3x3 elementary rotation matrix about X, Y or Z, or the identity, for an angle in
// degrees, with a fully pipelined CORDIC for sine and cosine.
// ============================================================================
// Usage:
//   Input channel: drive in_req_type and in_angle_deg and raise start; the
//   word is taken at the rising edge where start is high and busy is low.
//   busy is high only in reset and the cycle after, so a new word can be
//   taken on every cycle.
//   Result channel: out_valid marks the nine out_m* entries for exactly one
//   cycle; they are signed with FRAC_BITS fraction bits in 18-bit fields.
//   Pipeline: four stages of angle reduction, one stage per CORDIC
//   micro-rotation, one stage of rounding and one of matrix assembly.
//   Throughput: one word per cycle, set by the fully pipelined CORDIC.
//   Reset clears every valid bit, so no result appears from words in flight.
//   The receiver cannot stall; results are never held back.
// ============================================================================
module axis_rotation_matrix_generator
  import armg_pkg::*;
#(
  parameter int CORDIC_STAGES = 18,
  parameter int FRAC_BITS     = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [SEL_W-1:0]        in_req_type,
  input  logic signed [ANG_W-1:0] in_angle_deg,
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] out_m00,
  output logic signed [OUT_W-1:0] out_m01,
  output logic signed [OUT_W-1:0] out_m02,
  output logic signed [OUT_W-1:0] out_m10,
  output logic signed [OUT_W-1:0] out_m11,
  output logic signed [OUT_W-1:0] out_m12,
  output logic signed [OUT_W-1:0] out_m20,
  output logic signed [OUT_W-1:0] out_m21,
  output logic signed [OUT_W-1:0] out_m22
);

  localparam int ENT_W = FRAC_BITS + 2;

  // Hold off input while the pipeline comes out of reset.
  logic busy_r;
  logic accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // Angle reduction.
  logic                   red_valid;
  tag_t                   red_tag;
  logic signed [XY_W-1:0] red_z;

  armg_angle_reduce u_reduce (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (accept),
    .in_sel   (in_req_type),
    .in_angle (in_angle_deg),
    .z_valid  (red_valid),
    .z_tag    (red_tag),
    .z_ang    (red_z)
  );

  // Sine and cosine of the residual.
  logic                   cor_valid;
  tag_t                   cor_tag;
  logic signed [XY_W-1:0] cor_x;
  logic signed [XY_W-1:0] cor_y;

  armg_cordic #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (red_valid),
    .in_tag    (red_tag),
    .in_z      (red_z),
    .out_valid (cor_valid),
    .out_tag   (cor_tag),
    .out_x     (cor_x),
    .out_y     (cor_y)
  );

  // Matrix assembly.
  logic signed [ENT_W-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;

  armg_matrix #(
    .FRAC_BITS (FRAC_BITS)
  ) u_matrix (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cor_valid),
    .in_tag    (cor_tag),
    .in_x      (cor_x),
    .in_y      (cor_y),
    .out_valid (out_valid),
    .m00       (e00),
    .m01       (e01),
    .m02       (e02),
    .m10       (e10),
    .m11       (e11),
    .m12       (e12),
    .m20       (e20),
    .m21       (e21),
    .m22       (e22)
  );

  // Sign-extend or wrap each entry into its 18-bit field.
  assign out_m00 = OUT_W'(e00);
  assign out_m01 = OUT_W'(e01);
  assign out_m02 = OUT_W'(e02);
  assign out_m10 = OUT_W'(e10);
  assign out_m11 = OUT_W'(e11);
  assign out_m12 = OUT_W'(e12);
  assign out_m20 = OUT_W'(e20);
  assign out_m21 = OUT_W'(e21);
  assign out_m22 = OUT_W'(e22);

endmodule

// ===== rtl/core/armg_angle_reduce.sv =====
// ============================================================================
// Angle reduction front end
// Wraps the angle modulo 360 degrees, splits off the quadrant and scales the
// residual to radians in Q38, over four register stages.
// ============================================================================
module armg_angle_reduce
  import armg_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [SEL_W-1:0]       in_sel,
  input  logic signed [ANG_W-1:0] in_angle,
  output logic                   z_valid,
  output tag_t                   z_tag,
  output logic signed [XY_W-1:0] z_ang
);

  // Stage 1: bias to a positive value and estimate the quadrant count.
  logic [V_W-1:0]  v_nxt;
  logic [RQ_W-1:0] qprod;
  logic [V_W-1:0]  v1_r;
  logic [QQ_W-1:0] qq1_r;
  logic [SEL_W-1:0] sel1_r;
  logic            val1_r;

  assign v_nxt = V_W'({~in_angle[ANG_W-1], in_angle[ANG_W-2:0]}) + V_W'(ANGLE_BIAS);
  assign qprod = RQ_W'(v_nxt[V_W-1:T_SHIFT]) * RQ_W'(RECIP_45);

  // Stage 2: residual within the quadrant.
  logic [V_W-1:0] qbase;
  logic [R_W-1:0] rem_nxt;
  logic [R_W-1:0] r2_r;
  tag_t           tag2_r;
  logic           val2_r;

  assign qbase   = V_W'(qq1_r) * V_W'(QUAD_UNITS);
  assign rem_nxt = R_W'(v1_r - qbase);

  // Stage 3: residual times the radian step.
  logic [ZP_W-1:0] zp3_r;
  tag_t            tag3_r;
  logic            val3_r;

  // Stage 4: round to nearest at the working precision.
  logic [ZP_W-1:0]       zr;
  logic signed [XY_W-1:0] z4_r;
  tag_t                  tag4_r;
  logic                  val4_r;

  assign zr = zp3_r + (ZP_W'(1) << (Z_SH - 1));

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val1_r <= 1'b0;
      val2_r <= 1'b0;
      val3_r <= 1'b0;
      val4_r <= 1'b0;
    end else begin
      val1_r <= in_valid;
      val2_r <= val1_r;
      val3_r <= val2_r;
      val4_r <= val3_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    v1_r        <= v_nxt;
    qq1_r       <= qprod[RECIP_SHIFT +: QQ_W];
    sel1_r      <= in_sel;
    r2_r        <= rem_nxt;
    tag2_r.sel  <= sel1_r;
    tag2_r.quad <= qq1_r[1:0];
    tag2_r.zero <= (rem_nxt == '0);
    zp3_r       <= ZP_W'(r2_r) * ZP_W'(UNIT_RAD_Q45);
    tag3_r      <= tag2_r;
    z4_r        <= XY_W'(zr >> Z_SH);
    tag4_r      <= tag3_r;
  end

  assign z_valid = val4_r;
  assign z_tag   = tag4_r;
  assign z_ang   = z4_r;

endmodule

// ===== rtl/core/armg_cordic.sv =====
// ============================================================================
// Pipelined rotation-mode CORDIC
// One micro-rotation per register stage; cosine and sine of the residual
// angle come out of the last stage.
// ============================================================================
module armg_cordic
  import armg_pkg::*;
#(
  parameter int CORDIC_STAGES = 18
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  tag_t                   in_tag,
  input  logic signed [XY_W-1:0] in_z,
  output logic                   out_valid,
  output tag_t                   out_tag,
  output logic signed [XY_W-1:0] out_x,
  output logic signed [XY_W-1:0] out_y
);

  logic signed [XY_W-1:0] x_r   [CORDIC_STAGES];
  logic signed [XY_W-1:0] y_r   [CORDIC_STAGES];
  logic signed [XY_W-1:0] z_r   [CORDIC_STAGES];
  tag_t                   tag_r [CORDIC_STAGES];
  logic                   val_r [CORDIC_STAGES];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    localparam logic signed [XY_W-1:0] ANG = XY_W'(ATAN_Q38[i]);

    logic signed [XY_W-1:0] x_in;
    logic signed [XY_W-1:0] y_in;
    logic signed [XY_W-1:0] z_in;
    tag_t                   tag_in;
    logic                   val_in;

    // The first stage starts from the inverse gain on the x axis.
    if (i == 0) begin : g_first
      assign x_in   = XY_W'(GAIN_Q38);
      assign y_in   = '0;
      assign z_in   = in_z;
      assign tag_in = in_tag;
      assign val_in = in_valid;
    end else begin : g_next
      assign x_in   = x_r[i-1];
      assign y_in   = y_r[i-1];
      assign z_in   = z_r[i-1];
      assign tag_in = tag_r[i-1];
      assign val_in = val_r[i-1];
    end

    // Valid bit of this stage.
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        val_r[i] <= 1'b0;
      end else begin
        val_r[i] <= val_in;
      end
    end

    // Rotate toward the residual angle by atan(2^-i).
    always_ff @(posedge clk) begin
      if (z_in >= 0) begin
        x_r[i] <= x_in - (y_in >>> i);
        y_r[i] <= y_in + (x_in >>> i);
        z_r[i] <= z_in - ANG;
      end else begin
        x_r[i] <= x_in + (y_in >>> i);
        y_r[i] <= y_in - (x_in >>> i);
        z_r[i] <= z_in + ANG;
      end
      tag_r[i] <= tag_in;
    end
  end

  assign out_valid = val_r[CORDIC_STAGES-1];
  assign out_tag   = tag_r[CORDIC_STAGES-1];
  assign out_x     = x_r[CORDIC_STAGES-1];
  assign out_y     = y_r[CORDIC_STAGES-1];

endmodule

// ===== rtl/core/armg_matrix.sv =====
// ============================================================================
// Matrix assembly back end
// Rounds and clamps cosine and sine, unfolds the quadrant and places the
// entries of the elementary rotation matrix, over two register stages.
// ============================================================================
module armg_matrix
  import armg_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  tag_t                        in_tag,
  input  logic signed [XY_W-1:0]      in_x,
  input  logic signed [XY_W-1:0]      in_y,
  output logic                        out_valid,
  output logic signed [FRAC_BITS+1:0] m00,
  output logic signed [FRAC_BITS+1:0] m01,
  output logic signed [FRAC_BITS+1:0] m02,
  output logic signed [FRAC_BITS+1:0] m10,
  output logic signed [FRAC_BITS+1:0] m11,
  output logic signed [FRAC_BITS+1:0] m12,
  output logic signed [FRAC_BITS+1:0] m20,
  output logic signed [FRAC_BITS+1:0] m21,
  output logic signed [FRAC_BITS+1:0] m22
);

  `include "axis_rotation_matrix_generator_macros.svh"

  localparam int ENT_W = FRAC_BITS + 2;
  localparam int SH    = WORK_BITS - FRAC_BITS;
  localparam logic signed [XY_W-1:0]  HALF_W  = XY_W'(1) << (SH - 1);
  localparam logic signed [XY_W-1:0]  ONE_W   = XY_W'(1) << FRAC_BITS;
  localparam logic signed [XY_W-1:0]  MONE_W  = -ONE_W;
  localparam logic signed [ENT_W-1:0] ONE_E   = ENT_W'(1) << FRAC_BITS;
  localparam logic signed [ENT_W-1:0] ZERO_E  = '0;

  // Stage 1: round to nearest with ties up, then clamp to plus or minus one.
  logic signed [XY_W-1:0]  rx;
  logic signed [XY_W-1:0]  ry;
  logic signed [ENT_W-1:0] cr_nxt;
  logic signed [ENT_W-1:0] sr_nxt;
  logic signed [ENT_W-1:0] cr_r;
  logic signed [ENT_W-1:0] sr_r;
  tag_t                    tag1_r;
  logic                    val1_r;

  assign rx = (in_x + HALF_W) >>> SH;
  assign ry = (in_y + HALF_W) >>> SH;

  always_comb begin
    cr_nxt = ENT_W'(rx);
    sr_nxt = ENT_W'(ry);
    if (rx > ONE_W) begin
      cr_nxt = ONE_E;
    end else if (rx < MONE_W) begin
      cr_nxt = -ONE_E;
    end
    if (ry > ONE_W) begin
      sr_nxt = ONE_E;
    end else if (ry < MONE_W) begin
      sr_nxt = -ONE_E;
    end
    // A residual of exactly zero gives exact cosine and sine.
    if (in_tag.zero) begin
      cr_nxt = ONE_E;
      sr_nxt = ZERO_E;
    end
  end

  // Stage 2: unfold the quadrant and place the entries.
  logic signed [ENT_W-1:0] cs;
  logic signed [ENT_W-1:0] sn;
  logic signed [ENT_W-1:0] e_nxt [9];
  logic signed [ENT_W-1:0] e_r   [9];
  logic [SEL_W-1:0]        sel2_r;
  logic                    val2_r;

  always_comb begin
    case (tag1_r.quad)
      QUAD_0:  begin cs = cr_r;  sn = sr_r;  end
      QUAD_1:  begin cs = -sr_r; sn = cr_r;  end
      QUAD_2:  begin cs = -cr_r; sn = -sr_r; end
      default: begin cs = sr_r;  sn = -cr_r; end
    endcase
  end

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      e_nxt[k] = ZERO_E;
    end
    unique case (tag1_r.sel)
      SEL_X: begin
        e_nxt[0] = ONE_E;
        e_nxt[4] = cs;
        e_nxt[5] = -sn;
        e_nxt[7] = sn;
        e_nxt[8] = cs;
      end
      SEL_Y: begin
        e_nxt[0] = cs;
        e_nxt[2] = sn;
        e_nxt[4] = ONE_E;
        e_nxt[6] = -sn;
        e_nxt[8] = cs;
      end
      SEL_Z: begin
        e_nxt[0] = cs;
        e_nxt[1] = -sn;
        e_nxt[3] = sn;
        e_nxt[4] = cs;
        e_nxt[8] = ONE_E;
      end
      default: begin
        e_nxt[0] = ONE_E;
        e_nxt[4] = ONE_E;
        e_nxt[8] = ONE_E;
      end
    endcase
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val1_r <= 1'b0;
      val2_r <= 1'b0;
    end else begin
      val1_r <= in_valid;
      val2_r <= val1_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cr_r   <= cr_nxt;
    sr_r   <= sr_nxt;
    tag1_r <= in_tag;
    sel2_r <= tag1_r.sel;
    for (int k = 0; k < 9; k++) begin
      e_r[k] <= e_nxt[k];
    end
  end

  assign out_valid = val2_r;
  assign m00 = e_r[0];
  assign m01 = e_r[1];
  assign m02 = e_r[2];
  assign m10 = e_r[3];
  assign m11 = e_r[4];
  assign m12 = e_r[5];
  assign m20 = e_r[6];
  assign m21 = e_r[7];
  assign m22 = e_r[8];

  // Each axis word must have the shape of a rotation in its plane.
  `ARMG_ASSERT_IMPL(a_rot_x, clk, rst_n, val2_r && sel2_r == SEL_X,
    e_r[4] == e_r[8] && e_r[5] == -e_r[7] && e_r[0] == ONE_E)
  `ARMG_ASSERT_IMPL(a_rot_y, clk, rst_n, val2_r && sel2_r == SEL_Y,
    e_r[0] == e_r[8] && e_r[2] == -e_r[6] && e_r[4] == ONE_E)
  `ARMG_ASSERT_IMPL(a_rot_z, clk, rst_n, val2_r && sel2_r == SEL_Z,
    e_r[0] == e_r[4] && e_r[1] == -e_r[3] && e_r[8] == ONE_E)
  // A zero angle about X gives an exact unit cosine in the next cycle.
  `ARMG_ASSERT_NEXT(a_zero_exact, clk, rst_n,
    val1_r && tag1_r.zero && tag1_r.quad == QUAD_0 && tag1_r.sel == SEL_X,
    e_r[4] == ONE_E && e_r[7] == ZERO_E)

endmodule

// ===== tb/sv/rotation_matrix_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Rotation matrix checker
// Watches the command and result channels of the axis rotation matrix
// generator. It predicts the matrix for every accepted word with its own
// integer CORDIC and compares each result word entry by entry, in order.
// ============================================================================
module rotation_matrix_checker
  import armg_pkg::*;
#(
  parameter int CORDIC_STAGES = 18,
  parameter int FRAC_BITS     = 16,
  parameter int TRIG_TOL      = 2,
  parameter int MAX_PRINTED   = 40
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    busy,
  input  logic [SEL_W-1:0]        req_type,
  input  logic signed [ANG_W-1:0] angle_deg,
  input  logic                    out_valid,
  input  logic signed [OUT_W-1:0] out_m00,
  input  logic signed [OUT_W-1:0] out_m01,
  input  logic signed [OUT_W-1:0] out_m02,
  input  logic signed [OUT_W-1:0] out_m10,
  input  logic signed [OUT_W-1:0] out_m11,
  input  logic signed [OUT_W-1:0] out_m12,
  input  logic signed [OUT_W-1:0] out_m20,
  input  logic signed [OUT_W-1:0] out_m21,
  input  logic signed [OUT_W-1:0] out_m22,
  output int                      fail_count,
  output int                      pending,
  output int                      results_seen
);

  // One predicted matrix; trig marks the sine and cosine entries that may
  // differ from the prediction by up to TRIG_TOL LSB.
  typedef struct packed {
    logic [8:0]            trig;
    logic [8:0][OUT_W-1:0] ent;
  } matrix_t;

  localparam longint ONE        = longint'(1) << FRAC_BITS;
  localparam int     TURN_UNITS = 4 * QUAD_UNITS;

  longint  atan_table [CORDIC_STAGES];
  longint  inv_gain;
  longint  unit_rad_q60;
  matrix_t matrix_q [$];
  int      mismatches = 0;
  int      matrices   = 0;

  assign fail_count   = mismatches;
  assign results_seen = matrices;

  // Arctangent of 1/n in Q60 by the alternating series.
  function automatic longint atan_recip(longint n);
    longint term;
    longint nsq;
    longint sum;
    longint k;
    term = (longint'(1) << 60) / n;
    nsq  = n * n;
    sum  = 0;
    k    = 0;
    while (term > 0) begin
      if (k[0] == 1'b0) sum += term / (2 * k + 1);
      else sum -= term / (2 * k + 1);
      term /= nsq;
      k++;
    end
    return sum;
  endfunction

  // Round a Q60 value to the working precision.
  function automatic longint to_work(longint v);
    return (v + (longint'(1) << (59 - WORK_BITS))) >>> (60 - WORK_BITS);
  endfunction

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   -= res + bitv;
        res  = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Round a working value to the output fraction and clamp to [-1, +1].
  function automatic longint round_entry(longint v);
    longint r;
    r = (v + (longint'(1) << (WORK_BITS - FRAC_BITS - 1))) >>> (WORK_BITS - FRAC_BITS);
    if (r > ONE) r = ONE;
    if (r < -ONE) r = -ONE;
    return r;
  endfunction

  // Arctangent table, inverse gain and degree step, built once.
  initial begin
    longint          pi_q60;
    longint unsigned prod;
    longint unsigned root;
    pi_q60        = 16 * atan_recip(5) - 4 * atan_recip(239);
    atan_table[0] = to_work(pi_q60 / 4);
    for (int i = 1; i < CORDIC_STAGES; i++) begin
      atan_table[i] = to_work(atan_recip(longint'(1) << i));
    end
    unit_rad_q60 = pi_q60 / (180 * 256);
    prod = 64'd1 << 60;
    for (int i = 0; i < CORDIC_STAGES; i++) prod += prod >> (2 * i);
    root = isqrt(prod);
    if (root == 0) root = 1;
    inv_gain = longint'(((64'd1 << 62) / root) << (WORK_BITS - 32));
  end

  // Expected matrix for one command word.
  function automatic matrix_t predict_matrix(logic [SEL_W-1:0] sel,
                                             logic signed [ANG_W-1:0] ang);
    longint     a, m, r, x, y, z, dx, dy, cr, sr, cs, sn;
    longint     e [9];
    logic [1:0] quad;
    matrix_t    res;
    a = longint'(ang);
    m = a % TURN_UNITS;
    if (m < 0) m += TURN_UNITS;
    quad = 2'(m / QUAD_UNITS);
    r    = m % QUAD_UNITS;

    // Residual angle in [0, 90) degrees; zero gives exact values.
    if (r == 0) begin
      cr = ONE;
      sr = 0;
    end else begin
      x = inv_gain;
      y = 0;
      z = to_work(r * unit_rad_q60);
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx;
          y += dy;
          z -= atan_table[i];
        end else begin
          x += dx;
          y -= dy;
          z += atan_table[i];
        end
      end
      cr = round_entry(x);
      sr = round_entry(y);
    end

    // Fold the quadrant back in.
    case (quad)
      QUAD_0: begin
        cs = cr;
        sn = sr;
      end
      QUAD_1: begin
        cs = -sr;
        sn = cr;
      end
      QUAD_2: begin
        cs = -cr;
        sn = -sr;
      end
      default: begin
        cs = sr;
        sn = -cr;
      end
    endcase

    // Place the entries for the chosen axis.
    for (int i = 0; i < 9; i++) e[i] = 0;
    res.trig = '0;
    case (sel)
      SEL_X: begin
        e[0] = ONE;
        e[4] = cs;
        e[5] = -sn;
        e[7] = sn;
        e[8] = cs;
        res.trig[4] = 1'b1;
        res.trig[5] = 1'b1;
        res.trig[7] = 1'b1;
        res.trig[8] = 1'b1;
      end
      SEL_Y: begin
        e[0] = cs;
        e[2] = sn;
        e[4] = ONE;
        e[6] = -sn;
        e[8] = cs;
        res.trig[0] = 1'b1;
        res.trig[2] = 1'b1;
        res.trig[6] = 1'b1;
        res.trig[8] = 1'b1;
      end
      SEL_Z: begin
        e[0] = cs;
        e[1] = -sn;
        e[3] = sn;
        e[4] = cs;
        e[8] = ONE;
        res.trig[0] = 1'b1;
        res.trig[1] = 1'b1;
        res.trig[3] = 1'b1;
        res.trig[4] = 1'b1;
      end
      default: begin
        e[0] = ONE;
        e[4] = ONE;
        e[8] = ONE;
      end
    endcase
    if (r == 0) res.trig = '0;
    for (int i = 0; i < 9; i++) res.ent[i] = e[i][OUT_W-1:0];
    return res;
  endfunction

  // One line per mismatch; the printout is capped but every one is counted.
  task automatic report_mismatch(string msg);
    if (mismatches < MAX_PRINTED) $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Compare result words first, then record the word taken at this edge.
  always @(posedge clk) begin
    matrix_t               want;
    logic [8:0][OUT_W-1:0] got;
    int                    diff;
    if (rst_n) begin
      if (out_valid) begin
        matrices++;
        got = {out_m22, out_m21, out_m20, out_m12, out_m11, out_m10,
               out_m02, out_m01, out_m00};
        if (matrix_q.size() == 0) begin
          report_mismatch("result word with no command word waiting");
        end else begin
          want = matrix_q.pop_front();
          for (int i = 0; i < 9; i++) begin
            if (!want.trig[i] || $isunknown(got[i])) begin
              if (got[i] !== want.ent[i])
                report_mismatch($sformatf("m%0d%0d got %0d want %0d", i / 3, i % 3,
                                          $signed(got[i]), $signed(want.ent[i])));
            end else begin
              diff = int'($signed(got[i])) - int'($signed(want.ent[i]));
              if (diff > TRIG_TOL || diff < -TRIG_TOL)
                report_mismatch($sformatf("m%0d%0d got %0d want %0d (+/-%0d)",
                                          i / 3, i % 3, $signed(got[i]),
                                          $signed(want.ent[i]), TRIG_TOL));
            end
          end
        end
      end
      if (start && !busy) matrix_q.push_back(predict_matrix(req_type, angle_deg));
    end
    pending <= matrix_q.size();
  end

endmodule

// ===== tb/sv/tb_axis_rotation_matrix_generator.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Axis rotation matrix generator testbench
// Drives directed and random command words in bursts with random gaps and
// one full drain, and leaves prediction and comparison to the checker.
// ============================================================================
module tb_axis_rotation_matrix_generator
  import armg_pkg::*;
();

  localparam int NUM_WORDS  = 850;
  localparam int LATENCY    = 24;
  localparam int DRAIN_WAIT = 2000;

  logic                    clk          = 1'b0;
  logic                    rst_n        = 1'b0;
  logic                    start        = 1'b0;
  logic [SEL_W-1:0]        in_req_type  = '0;
  logic signed [ANG_W-1:0] in_angle_deg = '0;
  logic                    busy;
  logic                    out_valid;
  logic signed [OUT_W-1:0] out_m00, out_m01, out_m02;
  logic signed [OUT_W-1:0] out_m10, out_m11, out_m12;
  logic signed [OUT_W-1:0] out_m20, out_m21, out_m22;
  int                      fail_count;
  int                      pending;
  int                      results_seen;
  int                      axis_count [4] = '{0, 0, 0, 0};
  int                      words_sent     = 0;

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  axis_rotation_matrix_generator u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_req_type  (in_req_type),
    .in_angle_deg (in_angle_deg),
    .out_valid    (out_valid),
    .out_m00      (out_m00),
    .out_m01      (out_m01),
    .out_m02      (out_m02),
    .out_m10      (out_m10),
    .out_m11      (out_m11),
    .out_m12      (out_m12),
    .out_m20      (out_m20),
    .out_m21      (out_m21),
    .out_m22      (out_m22)
  );

  rotation_matrix_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .req_type     (in_req_type),
    .angle_deg    (in_angle_deg),
    .out_valid    (out_valid),
    .out_m00      (out_m00),
    .out_m01      (out_m01),
    .out_m02      (out_m02),
    .out_m10      (out_m10),
    .out_m11      (out_m11),
    .out_m12      (out_m12),
    .out_m20      (out_m20),
    .out_m21      (out_m21),
    .out_m22      (out_m22),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  // Present one command word and hold it until the block takes it.
  task automatic send_word(logic [SEL_W-1:0] sel, logic [ANG_W-1:0] ang);
    start        <= 1'b1;
    in_req_type  <= sel;
    in_angle_deg <= ang;
    @(posedge clk);
    while (busy) @(posedge clk);
    axis_count[sel]++;
    words_sent++;
  endtask

  // Drop start for a number of cycles; zero keeps the stream back to back.
  task automatic idle_cycles(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Random angle: mostly full range, with small angles, exact quadrant
  // multiples and words just around quadrant boundaries mixed in.
  function automatic logic [ANG_W-1:0] random_angle();
    int v;
    int k;
    k = int'($urandom_range(0, 728)) - 364;
    case ($urandom_range(0, 9))
      5, 6:    v = int'($urandom_range(0, 184320)) - 92160;
      7:       v = k * QUAD_UNITS;
      8, 9:    v = k * QUAD_UNITS + int'($urandom_range(0, 8)) - 4;
      default: v = int'($urandom);
    endcase
    return v[ANG_W-1:0];
  endfunction

  // Stimulus and verdict.
  initial begin
    int directed_ang [16];
    int burst;
    int waited;
    bit drained;
    directed_ang = '{0, 1, -1, 23040, 46080, 69120, 92160, -23040,
                     11520, -11520, 7680, 15360, 23039, 23041,
                     8386560, -8386560};
    drained = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words: quadrant points, boundaries and the field extremes.
    for (int i = 0; i < 16; i++) send_word(2'(i % 4), directed_ang[i][ANG_W-1:0]);
    for (int s = 0; s < 4; s++) begin
      send_word(2'(s), 24'h7FFFFF);
      send_word(2'(s), 24'h800000);
    end

    // Random bursts with gaps of varying length between them.
    while (words_sent < NUM_WORDS) begin
      burst = $urandom_range(1, 24);
      for (int b = 0; b < burst && words_sent < NUM_WORDS; b++)
        send_word(2'($urandom_range(0, 3)), random_angle());
      if (!drained && words_sent >= NUM_WORDS / 2) begin
        // Let the pipeline run empty once before going on.
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        drained = 1'b1;
      end
      case ($urandom_range(0, 7))
        0, 1:    idle_cycles(0);
        6:       idle_cycles($urandom_range(5, 12));
        7:       idle_cycles($urandom_range(20, 40));
        default: idle_cycles($urandom_range(1, 4));
      endcase
    end

    // Wait for the last results, then a little longer for stray words.
    start <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (pending != 0 && waited < DRAIN_WAIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 6) @(posedge clk);
    if (pending != 0) $display("%0d expected result words never arrived", pending);

    $display("Sent %0d words: X %0d, Y %0d, Z %0d, identity %0d, in bursts with gaps.",
             words_sent, axis_count[0], axis_count[1], axis_count[2], axis_count[3]);
    $display("Checked %0d result words, with one full drain of the pipeline.",
             results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_axis_rotation_matrix_generator: PASS");
    end else begin
      $display("tb_axis_rotation_matrix_generator: FAIL");
    end
    $finish;
  end

  // Watchdog for a hung handshake or a pipeline that never drains.
  initial begin
    #2000000;
    $display("tb_axis_rotation_matrix_generator: FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/armg_pkg.sv
rtl/core/armg_angle_reduce.sv
rtl/core/armg_cordic.sv
rtl/core/armg_matrix.sv
rtl/core/axis_rotation_matrix_generator.sv
tb/sv/rotation_matrix_checker.sv
tb/sv/tb_axis_rotation_matrix_generator.sv
